/* src/udpdt_pkg.sv */
// Shared types and constants of the UDP port demultiplex table.
// Used by the interfaces' users, the front end, the command queue, the back end and the top.
package udpdt_pkg;

  localparam int Slots      = 64;
  localparam int SlotIdxW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [15:0] AutoPortBaseRst   = 16'd1024;
  localparam logic [15:0] ReservedMaskRst   = 16'hFFC0;
  localparam logic [31:0] BroadcastAddrRst  = 32'hFFFF_FFFF;
  localparam logic [31:0] LocalAddrRst      = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_BIND   = 2'd1,
    OP_FREE   = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PORT  = 3'd1,
    ST_NOT_ALLOC = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_MATCH  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_AUTO_BASE  = 2'd0,
    CFG_RSV_MASK   = 2'd1,
    CFG_BCAST_ADDR = 2'd2,
    CFG_LOCAL_ADDR = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] auto_port_base;
    logic [15:0] reserved_port_mask;
    logic [31:0] broadcast_address;
    logic [31:0] local_address;
  } cfg_t;

  typedef struct packed {
    opcode_e     op;
    logic [5:0]  slot;
    logic [15:0] port;
    logic [31:0] addr;
    logic        bad_port;
  } cmd_t;

endpackage

/* src/udpdt_req_if.sv */
// Request channel of the UDP port demultiplex table: valid/ready and one request beat.
// No dependencies.
interface udpdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  slot;
  logic [15:0] port;
  logic [31:0] address;

  modport source (output valid, output opcode, output slot, output port, output address,
                  input ready);
  modport sink   (input valid, input opcode, input slot, input port, input address,
                  output ready);
endinterface

/* src/udpdt_rsp_if.sv */
// Response channel of the UDP port demultiplex table: valid/ready and one result beat.
// No dependencies.
interface udpdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  result_slot;
  logic [15:0] result_port;

  modport source (output valid, output status, output result_slot, output result_port,
                  input ready);
  modport sink   (input valid, input status, input result_slot, input result_port,
                  output ready);
endinterface

/* src/udpdt_front.sv */
// Front end: accepts request beats, rewrites broadcast lookups and checks reserved ports.
// Depends on udpdt_pkg and udpdt_req_if.
module udpdt_front
  import udpdt_pkg::*;
(
  udpdt_req_if.sink req_i,
  input  cfg_t      cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  opcode_e op;

  assign op          = opcode_e'(req_i.opcode);
  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    cmd_o.op       = op;
    cmd_o.slot     = req_i.slot;
    cmd_o.port     = req_i.port;
    cmd_o.addr     = req_i.address;
    cmd_o.bad_port = (req_i.port & cfg_i.reserved_port_mask) == cfg_i.auto_port_base;
    if (op == OP_LOOKUP && req_i.address == cfg_i.broadcast_address) begin
      cmd_o.addr = cfg_i.local_address;
    end
  end

endmodule

/* src/udpdt_queue.sv */
// Short command queue between front and back end of the demultiplex table.
// Depends on udpdt_pkg.
module udpdt_queue
  import udpdt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = count_q == (QueuePtrW + 1)'(QueueDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
    logic [QueuePtrW-1:0] n;
    n = (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* src/udpdt_back.sv */
// Back end: slot table, parallel match, priority select, table update and result register.
// Depends on udpdt_pkg and udpdt_rsp_if.
module udpdt_back
  import udpdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] auto_port_base_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  udpdt_rsp_if.source rsp_o
);

  typedef enum logic {S_EVAL, S_EXEC} state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [Slots-1:0]    vec_q;
  logic [Slots-1:0]    vec_d;
  logic                sel_ok_q;
  logic                sel_ok_d;
  logic [Slots-1:0]    valid_q;
  logic [15:0]         port_q [Slots];
  logic [31:0]         addr_q [Slots];

  logic [SlotIdxW-1:0] sel_idx;
  logic [SlotIdxW-1:0] exec_idx;
  logic                eval_fire;
  logic                exec_fire;
  logic                hit;
  logic [SlotIdxW-1:0] hit_idx;
  logic [15:0]         alloc_port;
  logic [15:0]         bind_port;

  status_e             status_d;
  logic [5:0]          rslot_d;
  logic [15:0]         rport_d;
  logic                set_valid;
  logic                clr_valid;
  logic                wr_en;
  logic [SlotIdxW-1:0] wr_idx;
  logic [15:0]         wr_port;
  logic [31:0]         wr_addr;

  assign sel_idx   = SlotIdxW'(cmd_i.slot);
  assign exec_idx  = SlotIdxW'(cmd_q.slot);
  assign eval_fire = (state_q == S_EVAL) && cmd_valid_i;
  assign exec_fire = (state_q == S_EXEC) && (!rsp_o.valid || rsp_o.ready);
  assign cmd_pop_o = eval_fire;

  // match vector: free slots for allocate, matching sockets otherwise
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      if (cmd_i.op == OP_ALLOC) begin
        vec_d[i] = !valid_q[i];
      end else begin
        vec_d[i] = valid_q[i] && (port_q[i] == cmd_i.port) &&
                   ((addr_q[i] == '0) || (addr_q[i] == cmd_i.addr));
      end
    end
  end

  assign sel_ok_d = (32'(cmd_i.slot) < 32'(Slots)) && valid_q[sel_idx];

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (vec_q[i]) begin
        hit     = 1'b1;
        hit_idx = SlotIdxW'(i);
      end
    end
  end

  assign alloc_port = auto_port_base_i + 16'(hit_idx);
  assign bind_port  = (cmd_q.port == '0) ? auto_port_base_i + 16'(exec_idx) : cmd_q.port;

  always_comb begin
    status_d  = ST_OK;
    rslot_d   = '0;
    rport_d   = '0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = exec_idx;
    wr_port   = bind_port;
    wr_addr   = cmd_q.addr;
    case (cmd_q.op)
      OP_ALLOC: begin
        if (hit) begin
          rslot_d   = 6'(hit_idx);
          rport_d   = alloc_port;
          set_valid = 1'b1;
          wr_en     = 1'b1;
          wr_idx    = hit_idx;
          wr_port   = alloc_port;
          wr_addr   = '0;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_BIND: begin
        if (cmd_q.bad_port) begin
          status_d = ST_BAD_PORT;
        end else if (!sel_ok_q) begin
          status_d = ST_NOT_ALLOC;
        end else begin
          rslot_d = cmd_q.slot;
          rport_d = bind_port;
          wr_en   = 1'b1;
        end
      end
      OP_FREE: begin
        if (!sel_ok_q) begin
          status_d = ST_NOT_ALLOC;
        end else begin
          rslot_d   = cmd_q.slot;
          clr_valid = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          rslot_d = 6'(hit_idx);
          rport_d = cmd_q.port;
        end else begin
          status_d = ST_NO_MATCH;
        end
      end
      default: begin
        status_d = ST_NO_MATCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_EVAL;
      valid_q           <= '0;
      rsp_o.valid       <= 1'b0;
      rsp_o.status      <= '0;
      rsp_o.result_slot <= '0;
      rsp_o.result_port <= '0;
    end else begin
      case (state_q)
        S_EVAL: begin
          if (eval_fire) begin
            state_q <= S_EXEC;
          end
          if (rsp_o.ready) begin
            rsp_o.valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_q           <= S_EVAL;
            rsp_o.valid       <= 1'b1;
            rsp_o.status      <= status_d;
            rsp_o.result_slot <= rslot_d;
            rsp_o.result_port <= rport_d;
            if (set_valid) begin
              valid_q[wr_idx] <= 1'b1;
            end
            if (clr_valid) begin
              valid_q[exec_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= S_EVAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      cmd_q    <= cmd_i;
      vec_q    <= vec_d;
      sel_ok_q <= sel_ok_d;
    end
    if (exec_fire && wr_en) begin
      port_q[wr_idx] <= wr_port;
      addr_q[wr_idx] <= wr_addr;
    end
  end

`ifndef ASSERT_OFF
  a_alloc_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && cmd_q.op == OP_ALLOC && hit |=> valid_q[$past(hit_idx)])
    else $error("allocated slot not marked valid");

  a_full_means_all_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && cmd_q.op == OP_ALLOC && !hit |-> &valid_q)
    else $error("table full reported with a free slot");

  a_free_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && cmd_q.op == OP_FREE && sel_ok_q |=> !valid_q[$past(exec_idx)])
    else $error("freed slot still valid");

  a_lookup_hits_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && cmd_q.op == OP_LOOKUP && hit |-> valid_q[hit_idx])
    else $error("lookup matched an unallocated slot");

  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && !exec_fire |=> state_q == S_EXEC)
    else $error("execute step left while result register busy");
`endif

endmodule

/* src/udp_port_demux_table.sv */
// UDP port demultiplex table of 64 receive slots. Every request beat is accepted into a
// two-entry command queue at one per cycle while the queue has room; the back end then
// takes each beat through an evaluate step, which compares it against all slot entries at
// once and registers the hit vector, and an execute step, which priority-selects the lowest
// slot, updates the table and loads the result register once it can take a result. The back
// end takes no new beat before it is through with the last. The user must write configuration
// through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the table is idle; the block does not enforce it.
module udp_port_demux_table
  import udpdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  udpdt_req_if.sink   req_i,
  udpdt_rsp_if.source rsp_o
);

  cfg_t cfg_q;
  logic push;
  logic full;
  logic empty;
  logic pop;
  cmd_t front_cmd;
  cmd_t queue_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_port_base     <= AutoPortBaseRst;
      cfg_q.reserved_port_mask <= ReservedMaskRst;
      cfg_q.broadcast_address  <= BroadcastAddrRst;
      cfg_q.local_address      <= LocalAddrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AUTO_BASE:  cfg_q.auto_port_base     <= cfg_wdata_i[15:0];
        CFG_RSV_MASK:   cfg_q.reserved_port_mask <= cfg_wdata_i[15:0];
        CFG_BCAST_ADDR: cfg_q.broadcast_address  <= cfg_wdata_i;
        CFG_LOCAL_ADDR: cfg_q.local_address      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  udpdt_front u_front (
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  udpdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (empty)
  );

  udpdt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .auto_port_base_i (cfg_q.auto_port_base),
    .cmd_valid_i      (!empty),
    .cmd_i            (queue_cmd),
    .cmd_pop_o        (pop),
    .rsp_o            (rsp_o)
  );

endmodule
